// ----- sv/fqsa_pkg.sv -----
// shared constants and controller/datapath interface types for queue admission
package fqsa_pkg;

    // queue sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int TIME_W  = 48;
    localparam int DUR_W   = 32;
    localparam int LIMIT_W = 5;
    localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);
    localparam logic [TIME_W-1:0]  TIME_MAX    = {TIME_W{1'b1}};

    // controller to datapath
    typedef struct packed {
        logic load;    // capture the incoming request
        logic pop;     // drop the fifo head entry
        logic commit;  // admission decision, write the result register
    } fqsa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic head_expired;  // head entry has started by the arrival time
        logic out_free;      // result register can take a new result
    } fqsa_status_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_POP    = 3'b010,
        ST_DECIDE = 3'b100
    } fqsa_state_t;

endpackage

// ----- sv/finite_queue_server_admission.sv -----
// top level of the finite-buffer single-server queue admission block
//
//  channel   direction  transfer when          payload
//  s_        in         s_valid && s_ready     s_arrival_time, s_service_duration
//  m_        out        m_valid && m_ready     m_accepted, m_finish_time
//  cfg_      in         cfg_we                 cfg_wdata (queue_limit)
//
// after a request transfer the fifo head is compared and dropped one entry per
// cycle while that entry has started by the request's arrival; then the decision
// is written into the result register, and only after that commit can the next
// request transfer.
// synchronous active-low reset clears the queue at once, no clearing pass.
// a new request is taken while the previous result waits in the output register;
// the decision step holds while that register is full and not being read.
module finite_queue_server_admission (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [fqsa_pkg::LIMIT_W-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fqsa_pkg::TIME_W-1:0]   s_arrival_time,
    input  logic [fqsa_pkg::DUR_W-1:0]    s_service_duration,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_accepted,
    output logic [fqsa_pkg::TIME_W-1:0]   m_finish_time
);
    import fqsa_pkg::*;

    fqsa_cmd_t    cmd;
    fqsa_status_t status;

    // sequencer
    fqsa_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // queue state and arithmetic
    fqsa_datapath u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_arrival_time     (s_arrival_time),
        .s_service_duration (s_service_duration),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_accepted         (m_accepted),
        .m_finish_time      (m_finish_time)
    );

    // checks
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.pop, cmd.commit}))
        else $error("more than one datapath command at once");

    a_pop_expired: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> status.head_expired)
        else $error("fifo entry dropped before its start time");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("decision not presented on the result channel");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_accepted) |-> (m_finish_time == '0))
        else $error("rejected request carries a nonzero finish time");

endmodule

// ----- sv/fqsa_datapath.sv -----
// request registers, start-time fifo, busy-until tracking and result register
module fqsa_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fqsa_pkg::fqsa_cmd_t           cmd,
    output fqsa_pkg::fqsa_status_t        status,
    input  logic                          cfg_we,
    input  logic [fqsa_pkg::LIMIT_W-1:0]  cfg_wdata,
    input  logic [fqsa_pkg::TIME_W-1:0]   s_arrival_time,
    input  logic [fqsa_pkg::DUR_W-1:0]    s_service_duration,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_accepted,
    output logic [fqsa_pkg::TIME_W-1:0]   m_finish_time
);
    import fqsa_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);

    logic [TIME_W-1:0]  fifo_reg [QUEUE_DEPTH];
    logic [TIME_W-1:0]  arrival_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic [TIME_W-1:0]  busy_reg, busy_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_acc_reg;
    logic [TIME_W-1:0]  out_fin_reg;

    logic [TIME_W-1:0]  head_start;
    logic               room;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W:0]    finish_sum;
    logic [TIME_W-1:0]  finish_time;
    logic [IDX_W:0]     tail_sum;
    logic [IDX_W-1:0]   tail_idx;
    logic [IDX_W-1:0]   head_inc;

    // head compare and output slot status
    assign head_start          = fifo_reg[head_reg];
    assign status.head_expired = (count_reg != '0) && (head_start <= arrival_reg);
    assign status.out_free     = !out_valid_reg || m_ready;

    // admission check against the configured limit, capped at the fifo depth
    assign room = (CMP_W'(count_reg) < CMP_W'(limit_reg)) && (count_reg < DEPTH_CNT);

    // start, saturating finish
    assign start_time  = (arrival_reg > busy_reg) ? arrival_reg : busy_reg;
    assign finish_sum  = {1'b0, start_time} + (TIME_W + 1)'(dur_reg);
    assign finish_time = finish_sum[TIME_W] ? TIME_MAX : finish_sum[TIME_W-1:0];

    // fifo positions with wrap
    assign tail_sum = {1'b0, head_reg} + (IDX_W + 1)'(count_reg);
    assign tail_idx = (tail_sum >= DEPTH_EXT) ? IDX_W'(tail_sum - DEPTH_EXT)
                                              : tail_sum[IDX_W-1:0];
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);

    // next state of the queue bookkeeping
    always_comb begin
        busy_next      = busy_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.pop) begin
            head_next  = head_inc;
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.commit) begin
            out_valid_next = 1'b1;
            if (room) begin
                busy_next  = finish_time;
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // payload registers: request, fifo push, result
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            arrival_reg <= s_arrival_time;
            dur_reg     <= s_service_duration;
        end
        if (cmd.commit) begin
            out_acc_reg <= room;
            out_fin_reg <= room ? finish_time : '0;
            if (room) begin
                fifo_reg[tail_idx] <= start_time;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_accepted    = out_acc_reg;
    assign m_finish_time = out_fin_reg;

endmodule

// ----- sv/fqsa_controller.sv -----
// sequencer: take a request, drop expired fifo entries, then decide
module fqsa_controller (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  fqsa_pkg::fqsa_status_t status,
    output fqsa_pkg::fqsa_cmd_t    cmd
);
    import fqsa_pkg::*;

    fqsa_state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                if (status.head_expired) begin
                    cmd.pop = 1'b1;
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for queue admission: random requests, limit changes, checked results
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fqsa_pkg::*;

    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 275;
    localparam int STALL_AT      = 1180;
    localparam int STALL_CYCLES  = 400;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic              accepted;
        logic [TIME_W-1:0] finish_time;
    } verdict_t;

    // admission predictor plus the queue of verdicts still owed by the block
    class admission_book;
        logic [TIME_W-1:0]  starts[QUEUE_DEPTH];
        int unsigned        head;
        int unsigned        waiting;
        logic [TIME_W-1:0]  busy_until;
        logic [LIMIT_W-1:0] limit;
        verdict_t           pending[$];
        int                 mismatches;

        function new();
            head       = 0;
            waiting    = 0;
            busy_until = '0;
            limit      = LIMIT_RESET;
            mismatches = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] value);
            limit = value;
        endfunction

        // note one accepted request and queue the verdict it must produce
        function void admit(logic [TIME_W-1:0] arrival, logic [DUR_W-1:0] duration);
            int unsigned       room;
            logic [TIME_W-1:0] start;
            logic [TIME_W:0]   finish;
            verdict_t          v;
            room = (int'(limit) > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(limit);
            // entries that have started by this arrival leave the queue
            while (waiting > 0 && starts[head] <= arrival) begin
                head    = (head + 1) % QUEUE_DEPTH;
                waiting = waiting - 1;
            end
            if (waiting < room) begin
                start  = (arrival > busy_until) ? arrival : busy_until;
                finish = {1'b0, start} + {17'd0, duration};
                if (finish > {1'b0, TIME_MAX})
                    finish = {1'b0, TIME_MAX};
                starts[(head + waiting) % QUEUE_DEPTH] = start;
                waiting       = waiting + 1;
                busy_until    = finish[TIME_W-1:0];
                v.accepted    = 1'b1;
                v.finish_time = finish[TIME_W-1:0];
            end else begin
                v.accepted    = 1'b0;
                v.finish_time = '0;
            end
            pending = {pending, v};
        endfunction

        // compare one result transfer against the oldest owed verdict
        function void check_verdict(logic accepted, logic [TIME_W-1:0] finish_time);
            verdict_t v;
            if (pending.size() == 0) begin
                $display("%0t: result with none expected, accepted %0b finish_time %0h",
                         $realtime, accepted, finish_time);
                mismatches++;
            end else begin
                v = pending.pop_front();
                if (accepted !== v.accepted) begin
                    $display("%0t: accepted mismatch, expected %0b actual %0b",
                             $realtime, v.accepted, accepted);
                    mismatches++;
                end
                if (finish_time !== v.finish_time) begin
                    $display("%0t: finish_time mismatch, expected %0h actual %0h",
                             $realtime, v.finish_time, finish_time);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [LIMIT_W-1:0]  cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [TIME_W-1:0]   s_arrival_time;
    logic [DUR_W-1:0]    s_service_duration;
    logic                m_valid;
    logic                m_ready;
    logic                m_accepted;
    logic [TIME_W-1:0]   m_finish_time;

    admission_book       book;
    int                  tx_idle_pct;
    int                  rx_idle_pct;
    int                  requests_sent;
    int                  gap_max;
    int                  dur_max;
    logic [TIME_W-1:0]   time_base;

    finite_queue_server_admission dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_arrival_time     (s_arrival_time),
        .s_service_duration (s_service_duration),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_accepted         (m_accepted),
        .m_finish_time      (m_finish_time)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result transfers
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            book.check_verdict(m_accepted, m_finish_time);
    end

    // receiver ready, with one long hold-off once STALL_AT requests have been sent
    initial begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!hold_done && requests_sent >= STALL_AT) begin
                hold_left = STALL_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
            @(posedge aclk);
        end
    end

    // one request transfer, with random idle cycles ahead of it
    task automatic offer_request(input logic [TIME_W-1:0] arrival,
                                 input logic [DUR_W-1:0] duration);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_arrival_time     <= arrival;
        s_service_duration <= duration;
        do @(posedge aclk); while (!s_ready);
        book.admit(arrival, duration);
        requests_sent++;
    endtask

    // limit write once every owed result has come back
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (book.pending.size() != 0) @(posedge aclk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        book.set_limit(value);
    endtask

    // mostly rising arrivals: repeats, small gaps, rare jumps and steps back
    function automatic logic [TIME_W-1:0] next_arrival();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            if (time_base > 48'd50)
                return time_base - 48'($urandom_range(1, 50));
            return time_base;
        end
        if (r < 8)
            time_base = time_base + 48'($urandom) * 48'($urandom_range(1, 4));
        else if (r >= 25)
            time_base = time_base + 48'($urandom_range(1, gap_max));
        return time_base;
    endfunction

    function automatic logic [DUR_W-1:0] next_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return '0;
        if (r < 4)
            return '1;
        if (r < 7)
            return $urandom;
        return DUR_W'($urandom_range(1, dur_max));
    endfunction

    // stimulus
    initial begin
        logic [LIMIT_W-1:0] lim;
        book          = new();
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        requests_sent = 0;
        gap_max       = 16;
        dur_max       = 32;
        time_base     = '0;

        aresetn            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        s_valid            <= 1'b0;
        s_arrival_time     <= '0;
        s_service_duration <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limit: zero duration, equal times, longest duration, queueing
        offer_request(48'd0, 32'd0);
        offer_request(48'd0, 32'd1);
        offer_request(48'd0, 32'd3);
        offer_request(48'd1, 32'd2);
        offer_request(48'd2, 32'd10);
        offer_request(48'd100, 32'hFFFF_FFFF);
        offer_request(48'd101, 32'd7);
        offer_request(48'd90, 32'd5);

        // zero limit rejects everything
        write_limit(5'd0);
        offer_request(48'h1_0000_0000, 32'd4);
        offer_request(48'h1_0000_0000, 32'd4);

        // limit of one: the third request, behind a future start, is dropped
        write_limit(5'd1);
        offer_request(48'h2_0000_0000, 32'd50);
        offer_request(48'h2_0000_0000, 32'd50);
        offer_request(48'h2_0000_0010, 32'd50);
        offer_request(48'h2_0000_0032, 32'd1);
        time_base = 48'h2_0000_0040;

        // random phases
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       lim = 5'd1;
                1:       lim = 5'd31;
                2:       lim = 5'd4;
                3:       lim = 5'($urandom_range(1, 31));
                4:       lim = 5'd16;
                default: lim = 5'($urandom_range(2, 8));
            endcase
            write_limit(lim);
            if (p < 2) begin
                tx_idle_pct = 15;
                rx_idle_pct = 66;
            end else if (p < 4) begin
                tx_idle_pct = 66;
                rx_idle_pct = 15;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            gap_max = $urandom_range(4, 64);
            dur_max = gap_max * $urandom_range(1, 4);
            // last phase runs with the top time bit set
            if (p == PHASES - 1)
                time_base = {2'b10, 46'($urandom) << 14} | 48'($urandom);
            for (int i = 0; i < PHASE_ITEMS; i++)
                offer_request(next_arrival(), next_duration());
        end

        // saturation at the top of the time range
        offer_request(TIME_MAX - 48'd10, 32'hFFFF_FFFF);
        offer_request(TIME_MAX - 48'd5, 32'd20);
        offer_request(TIME_MAX, 32'd5);
        offer_request(TIME_MAX, 32'd0);
        offer_request(TIME_MAX, 32'hFFFF_FFFF);
        s_valid <= 1'b0;

        // drain
        while (book.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (book.pending.size() != 0)
            $display("%0t: %0d results never arrived", $realtime, book.pending.size());
        if (book.mismatches == 0 && book.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
sv/fqsa_pkg.sv
sv/fqsa_datapath.sv
sv/fqsa_controller.sv
sv/finite_queue_server_admission.sv
bench/tb_top.sv
